[hdl/prd_pkg.sv]
// Package for the priority retry dispatcher: widths, codes, payload and control types.
`default_nettype none
package prd_pkg;

   // Field widths fixed by the interface
   localparam int FUNC_W   = 2;
   localparam int ID_W     = 16;
   localparam int PRIO_W   = 4;
   localparam int ATT_W    = 4;
   localparam int SEQ_W    = 32;
   localparam int STATUS_W = 4;
   localparam int BOFF_W   = 24;
   localparam int STAT_W   = 16;
   localparam int OCC_W    = 5;
   localparam int LIMIT_W  = 4;
   localparam int BASE_W   = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   // Default sizing
   localparam int DEF_QUEUE_DEPTH  = 16;
   localparam int DEF_MAX_PRIORITY = 10;

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKOFF_BASE = 1'd1;
   localparam logic [LIMIT_W-1:0]   RETRY_LIMIT_RESET  = 4'd2;
   localparam logic [BASE_W-1:0]    BACKOFF_BASE_RESET = 10'd100;

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_ENQUEUE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REPORT   = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] RSP_ENQUEUED   = 4'd0;
   localparam logic [STATUS_W-1:0] RSP_FULL       = 4'd1;
   localparam logic [STATUS_W-1:0] RSP_DISPATCHED = 4'd2;
   localparam logic [STATUS_W-1:0] RSP_EMPTY      = 4'd3;
   localparam logic [STATUS_W-1:0] RSP_BUSY       = 4'd4;
   localparam logic [STATUS_W-1:0] RSP_SUCCESS    = 4'd5;
   localparam logic [STATUS_W-1:0] RSP_REQUEUED   = 4'd6;
   localparam logic [STATUS_W-1:0] RSP_FINAL_FAIL = 4'd7;
   localparam logic [STATUS_W-1:0] RSP_DROPPED    = 4'd8;
   localparam logic [STATUS_W-1:0] RSP_NONE       = 4'd9;

   localparam logic [STAT_W-1:0] STAT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   job_id;
      logic [PRIO_W-1:0] priority_req;
      logic              failed;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     out_job_id;
      logic [PRIO_W-1:0]   out_priority;
      logic [ATT_W-1:0]    out_attempt;
      logic [BOFF_W-1:0]   backoff_ms;
      logic [STAT_W-1:0]   success_count;
      logic [STAT_W-1:0]   failure_count;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // One stored job
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [ATT_W-1:0]  attempt;
      logic [SEQ_W-1:0]  seq;
   } entry_type;

   // Store write strobes
   typedef struct packed {
      logic wr_en;
      logic clr_en;
   } store_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FIN
   } state_type;

endpackage
`default_nettype wire

[hdl/prd_store.sv]
// Job store: synchronous entry memory with per-slot valid flags and registered read.
`default_nettype none
module prd_store
   import prd_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire store_cmd_type st_cmd,
   input  wire logic [IDX_W-1:0] st_wr_addr,
   input  wire entry_type     st_wr_data,
   input  wire logic [IDX_W-1:0] st_rd_addr,
   output entry_type          st_rd_data,
   output logic               st_rd_valid
);

   entry_type mem [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_ff;
   entry_type rd_data_ff;
   logic      rd_valid_ff;

   // Entry write port
   always_ff @(posedge clock) begin
      if (st_cmd.wr_en) begin
         mem[st_wr_addr] <= st_wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff  <= mem[st_rd_addr];
      rd_valid_ff <= valid_ff[st_rd_addr];
   end

   // Valid flags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (st_cmd.wr_en) begin
         valid_ff[st_wr_addr] <= 1'b1;
      end else if (st_cmd.clr_en) begin
         valid_ff[st_wr_addr] <= 1'b0;
      end
   end

   assign st_rd_data  = rd_data_ff;
   assign st_rd_valid = rd_valid_ff;

endmodule
`default_nettype wire

[hdl/prd_ctrl.sv]
// Dispatcher control: transaction sequencer, store scan, running job and counters.
`default_nettype none
module prd_ctrl
   import prd_pkg::*;
#(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int MAX_PRIORITY = DEF_MAX_PRIORITY,
   localparam int IDX_W = $clog2(QUEUE_DEPTH),
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output store_cmd_type              st_cmd,
   output logic [IDX_W-1:0]           st_wr_addr,
   output entry_type                  st_wr_data,
   output logic [IDX_W-1:0]           st_rd_addr,
   input  wire entry_type             st_rd_data,
   input  wire logic                  st_rd_valid
);

   localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(QUEUE_DEPTH);
   localparam logic [PRIO_W-1:0] PMAX_C  = PRIO_W'(MAX_PRIORITY);

   state_type state_ff, state_in;

   req_type            req_ff;
   logic [LIMIT_W-1:0] retry_ff;
   logic [BASE_W-1:0]  base_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [STAT_W-1:0]  succ_ff, succ_in;
   logic [STAT_W-1:0]  fail_ff, fail_in;
   logic               run_valid_ff, run_valid_in;
   entry_type          run_ff, run_in;

   // Scan bookkeeping
   logic [CNT_W-1:0] iss_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] pidx_ff;
   entry_type        best_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic             best_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic             free_found_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff, res;

   logic accept, issue, rsp_free, commit, need_scan;
   logic put_en, take_en;
   logic [PRIO_W-1:0] clamp_prio;
   logic [SEQ_W-1:0]  seq_diff;
   logic              cand_better;
   entry_type         put_entry;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign issue    = (state_ff == S_SCAN) && (iss_ff != DEPTH_C);

   // Decide at accept whether the store must be swept
   always_comb begin
      case (req_payload.func)
         FUNC_ENQUEUE:  need_scan = (count_ff != DEPTH_C);
         FUNC_DISPATCH: need_scan = !run_valid_ff && (count_ff != '0);
         FUNC_REPORT:   need_scan = run_valid_ff && req_payload.failed &&
                                    (run_ff.attempt < retry_ff) && (count_ff != DEPTH_C);
         default:       need_scan = 1'b0;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            state_in = need_scan ? S_SCAN : S_FIN;
         end
         S_SCAN: if ((iss_ff == DEPTH_C) && !pend_ff) begin
            state_in = S_FIN;
         end
         S_FIN: if (rsp_free) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      commit        = (state_ff == S_FIN) && rsp_free;
      st_cmd.wr_en  = commit && put_en;
      st_cmd.clr_en = commit && take_en;
      st_rd_addr    = iss_ff[IDX_W-1:0];
   end

   // Candidate compare: higher priority, or equal priority and older tag
   assign seq_diff    = st_rd_data.seq - best_ff.seq;
   assign cand_better = !best_found_ff || (st_rd_data.prio > best_ff.prio) ||
                        ((st_rd_data.prio == best_ff.prio) && seq_diff[SEQ_W-1]);

   always_comb begin
      if (req_ff.priority_req == '0) begin
         clamp_prio = PRIO_W'(1);
      end else if (req_ff.priority_req > PMAX_C) begin
         clamp_prio = PMAX_C;
      end else begin
         clamp_prio = req_ff.priority_req;
      end
   end

   // Outcome of the transaction and the state it leaves
   always_comb begin
      res          = '0;
      res.status   = RSP_NONE;
      put_en       = 1'b0;
      take_en      = 1'b0;
      put_entry    = '0;
      put_entry.seq = seq_ff;
      run_valid_in = run_valid_ff;
      run_in       = run_ff;
      succ_in      = succ_ff;
      fail_in      = fail_ff;
      st_wr_addr   = free_idx_ff;
      case (req_ff.func)
         FUNC_ENQUEUE: begin
            res.out_job_id   = req_ff.job_id;
            res.out_priority = clamp_prio;
            if (count_ff == DEPTH_C) begin
               res.status = RSP_FULL;
            end else begin
               res.status     = RSP_ENQUEUED;
               put_en         = 1'b1;
               put_entry.id   = req_ff.job_id;
               put_entry.prio = clamp_prio;
            end
         end
         FUNC_DISPATCH: begin
            if (run_valid_ff) begin
               res.status       = RSP_BUSY;
               res.out_job_id   = run_ff.id;
               res.out_priority = run_ff.prio;
               res.out_attempt  = run_ff.attempt;
            end else if (!best_found_ff) begin
               res.status = RSP_EMPTY;
            end else begin
               res.status       = RSP_DISPATCHED;
               take_en          = 1'b1;
               st_wr_addr       = best_idx_ff;
               run_valid_in     = 1'b1;
               run_in           = best_ff;
               res.out_job_id   = best_ff.id;
               res.out_priority = best_ff.prio;
               res.out_attempt  = best_ff.attempt;
               if (best_ff.attempt != '0) begin
                  res.backoff_ms = BOFF_W'(BOFF_W'(base_ff) << (best_ff.attempt - 1'b1));
               end
            end
         end
         FUNC_REPORT: begin
            if (run_valid_ff) begin
               run_valid_in     = 1'b0;
               res.out_job_id   = run_ff.id;
               res.out_priority = run_ff.prio;
               res.out_attempt  = run_ff.attempt;
               if (!req_ff.failed) begin
                  res.status = RSP_SUCCESS;
                  succ_in    = (succ_ff == STAT_MAX) ? succ_ff : succ_ff + 1'b1;
               end else if (run_ff.attempt < retry_ff) begin
                  // Retry with aged priority
                  res.out_attempt  = run_ff.attempt + 1'b1;
                  res.out_priority = (run_ff.prio < PMAX_C) ? run_ff.prio + 1'b1 : PMAX_C;
                  if (count_ff != DEPTH_C) begin
                     res.status        = RSP_REQUEUED;
                     put_en            = 1'b1;
                     put_entry.id      = run_ff.id;
                     put_entry.prio    = res.out_priority;
                     put_entry.attempt = res.out_attempt;
                  end else begin
                     res.status = RSP_DROPPED;
                     fail_in    = (fail_ff == STAT_MAX) ? fail_ff : fail_ff + 1'b1;
                  end
               end else begin
                  res.status = RSP_FINAL_FAIL;
                  fail_in    = (fail_ff == STAT_MAX) ? fail_ff : fail_ff + 1'b1;
               end
            end
         end
         default: res.status = RSP_NONE;
      endcase
      count_in = count_ff;
      if (put_en) begin
         count_in = count_ff + 1'b1;
      end else if (take_en) begin
         count_in = count_ff - 1'b1;
      end
      res.success_count = succ_in;
      res.failure_count = fail_in;
      res.occupancy     = OCC_W'(count_in);
   end

   assign st_wr_data = put_entry;

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff <= RETRY_LIMIT_RESET;
         base_ff  <= BACKOFF_BASE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RETRY_LIMIT:  retry_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_BACKOFF_BASE: base_ff  <= csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // Latched request
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
   end

   // Store scan: issue one read a cycle, evaluate each entry in the cycle after its read
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         iss_ff        <= '0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         pend_ff <= issue;
         if (accept) begin
            iss_ff        <= '0;
            best_found_ff <= 1'b0;
            free_found_ff <= 1'b0;
         end else begin
            if (issue) begin
               iss_ff <= iss_ff + 1'b1;
            end
            if (pend_ff && st_rd_valid && cand_better) begin
               best_found_ff <= 1'b1;
            end
            if (pend_ff && !st_rd_valid) begin
               free_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= iss_ff[IDX_W-1:0];
      if (pend_ff && st_rd_valid && cand_better) begin
         best_ff     <= st_rd_data;
         best_idx_ff <= pidx_ff;
      end
      if (pend_ff && !st_rd_valid && !free_found_ff) begin
         free_idx_ff <= pidx_ff;
      end
   end

   // Job state and statistics, updated at commit
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= '0;
         count_ff     <= '0;
         succ_ff      <= '0;
         fail_ff      <= '0;
         run_valid_ff <= 1'b0;
      end else if (commit) begin
         if (put_en) begin
            seq_ff <= seq_ff + 1'b1;
         end
         count_ff     <= count_in;
         succ_ff      <= succ_in;
         fail_ff      <= fail_in;
         run_valid_ff <= run_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         run_ff <= run_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("waiting count exceeds store depth");

   a_write_at_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FIN) |-> !(st_cmd.wr_en || st_cmd.clr_en))
      else $error("store written outside commit");

   a_dispatch_runs: assert property (@(posedge clock) disable iff (reset)
      (commit && (res.status == RSP_DISPATCHED)) |=> run_valid_ff)
      else $error("dispatched job not running");

   a_put_counts: assert property (@(posedge clock) disable iff (reset)
      (commit && put_en) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("store insert did not bump the count");
`endif

endmodule
`default_nettype wire

[hdl/priority_retry_dispatcher.sv]
// Top level of the priority retry dispatcher: control sequencer plus job store.
//
// Usage:
//   Request channel (req_valid/req_ready/req_payload) carries one command:
//   enqueue, dispatch or outcome report. Response channel (rsp_*) returns
//   exactly one result per request, in order. CSR port writes retry_limit
//   (index 0) and backoff_base (index 1); the user must write it only while
//   idle, as the block does not enforce this. Commands that need the store
//   (enqueue with space, dispatch with jobs waiting and none running,
//   requeue after a failure) sweep all QUEUE_DEPTH entries through the
//   store read port, one per cycle. One command is in flight at a time, so
//   a new request is taken only after the previous one has committed.
//   A finished response waits in an output register; the next request is
//   accepted meanwhile, and its result is held in the sequencer until the
//   receiver takes the earlier one.
//   Reset (synchronous) empties the store, clears the running job, the
//   sequence counter and statistics, and restores the register defaults.
`default_nettype none
module priority_retry_dispatcher
   import prd_pkg::*;
#(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int MAX_PRIORITY = DEF_MAX_PRIORITY
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   store_cmd_type    st_cmd;
   logic [IDX_W-1:0] st_wr_addr;
   entry_type        st_wr_data;
   logic [IDX_W-1:0] st_rd_addr;
   entry_type        st_rd_data;
   logic             st_rd_valid;

   prd_ctrl #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .MAX_PRIORITY (MAX_PRIORITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .st_cmd      (st_cmd),
      .st_wr_addr  (st_wr_addr),
      .st_wr_data  (st_wr_data),
      .st_rd_addr  (st_rd_addr),
      .st_rd_data  (st_rd_data),
      .st_rd_valid (st_rd_valid)
   );

   prd_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .st_cmd      (st_cmd),
      .st_wr_addr  (st_wr_addr),
      .st_wr_data  (st_wr_data),
      .st_rd_addr  (st_rd_addr),
      .st_rd_data  (st_rd_data),
      .st_rd_valid (st_rd_valid)
   );

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the priority retry dispatcher: stimulus, prediction and checks.
module testbench
   import prd_pkg::*;
();

   localparam int DEPTH        = DEF_QUEUE_DEPTH;
   localparam int PRIO_TOP     = DEF_MAX_PRIORITY;
   localparam int SETTLE       = 25;     // longest command latency plus margin
   localparam int QUIET_LIMIT  = 3000;   // cycles without any transaction before giving up
   localparam int HOLD_AT      = 520;    // response count that starts the long receiver hold
   localparam int HOLD_CYCLES  = 300;

   // Function code with no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   priority_retry_dispatcher u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Commands waiting to be driven and results still owed by the block
   req_type cmd_backlog[$];
   rsp_type due_results[$];

   // Shadow of the dispatcher state
   logic                  slot_busy [DEPTH];
   entry_type             slot_job  [DEPTH];
   logic                  run_busy;
   entry_type             run_job;
   logic [SEQ_W-1:0]      next_seq;
   logic [STAT_W-1:0]     ok_total;
   logic [STAT_W-1:0]     lost_total;
   logic [OCC_W-1:0]      waiting;
   logic [LIMIT_W-1:0]    retry_cap;
   logic [BASE_W-1:0]     base_ms;

   int  status_seen [16];
   int  mismatches = 0;
   int  cmds_sent = 0;
   int  rsps_taken = 0;
   int  settings_used = 1;
   bit  no_idle = 1'b0;
   int  req_gap;
   int  rsp_wait;
   int  rsp_draw;
   int  quiet_cycles;

   function automatic int idle_draw();
      return no_idle ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic logic [STAT_W-1:0] sat_bump(input logic [STAT_W-1:0] v);
      return (v == STAT_MAX) ? v : v + 1'b1;
   endfunction

   // Tag a is older than tag b under modular comparison
   function automatic bit seq_before(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return d[SEQ_W-1];
   endfunction

   // Lowest free slot takes the job; returns 0 when the store is full
   function automatic bit store_job(input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] p,
                                    input logic [ATT_W-1:0] a);
      for (int i = 0; i < DEPTH; i++) begin
         if (!slot_busy[i]) begin
            slot_busy[i] = 1'b1;
            slot_job[i]  = '{id: id, prio: p, attempt: a, seq: next_seq};
            next_seq++;
            waiting++;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void clear_model();
      for (int i = 0; i < DEPTH; i++) begin
         slot_busy[i] = 1'b0;
         slot_job[i]  = '0;
      end
      run_busy   = 1'b0;
      run_job    = '0;
      next_seq   = '0;
      ok_total   = '0;
      lost_total = '0;
      waiting    = '0;
      retry_cap  = RETRY_LIMIT_RESET;
      base_ms    = BACKOFF_BASE_RESET;
   endfunction

   // Result of one command, with the shadow state advanced
   function automatic rsp_type command_result(input req_type c);
      rsp_type o;
      logic [PRIO_W-1:0] p;
      int pick;
      o = '0;
      o.status = RSP_NONE;
      case (c.func)
         FUNC_ENQUEUE: begin
            p = c.priority_req;
            if (p == 0) p = PRIO_W'(1);
            if (p > PRIO_TOP) p = PRIO_W'(PRIO_TOP);
            o.out_job_id   = c.job_id;
            o.out_priority = p;
            o.status = store_job(c.job_id, p, '0) ? RSP_ENQUEUED : RSP_FULL;
         end
         FUNC_DISPATCH: begin
            if (run_busy) begin
               o.status       = RSP_BUSY;
               o.out_job_id   = run_job.id;
               o.out_priority = run_job.prio;
               o.out_attempt  = run_job.attempt;
            end else begin
               pick = -1;
               for (int i = 0; i < DEPTH; i++) begin
                  if (slot_busy[i] && (pick < 0 || slot_job[i].prio > slot_job[pick].prio ||
                      (slot_job[i].prio == slot_job[pick].prio &&
                       seq_before(slot_job[i].seq, slot_job[pick].seq))))
                     pick = i;
               end
               if (pick < 0) begin
                  o.status = RSP_EMPTY;
               end else begin
                  run_job         = slot_job[pick];
                  run_busy        = 1'b1;
                  slot_busy[pick] = 1'b0;
                  waiting--;
                  o.status       = RSP_DISPATCHED;
                  o.out_job_id   = run_job.id;
                  o.out_priority = run_job.prio;
                  o.out_attempt  = run_job.attempt;
                  if (run_job.attempt != 0)
                     o.backoff_ms = BOFF_W'(32'(base_ms) << (run_job.attempt - 1'b1));
               end
            end
         end
         FUNC_REPORT: begin
            if (run_busy) begin
               run_busy       = 1'b0;
               o.out_job_id   = run_job.id;
               o.out_priority = run_job.prio;
               o.out_attempt  = run_job.attempt;
               if (!c.failed) begin
                  ok_total = sat_bump(ok_total);
                  o.status = RSP_SUCCESS;
               end else if (run_job.attempt < retry_cap) begin
                  // Retry: one more attempt, priority aged by one up to the top
                  o.out_attempt  = run_job.attempt + 1'b1;
                  o.out_priority = (run_job.prio < PRIO_TOP) ? run_job.prio + 1'b1
                                                             : PRIO_W'(PRIO_TOP);
                  if (store_job(o.out_job_id, o.out_priority, o.out_attempt)) begin
                     o.status = RSP_REQUEUED;
                  end else begin
                     lost_total = sat_bump(lost_total);
                     o.status   = RSP_DROPPED;
                  end
               end else begin
                  lost_total = sat_bump(lost_total);
                  o.status   = RSP_FINAL_FAIL;
               end
            end
         end
         default: ;
      endcase
      o.success_count = ok_total;
      o.failure_count = lost_total;
      o.occupancy     = waiting;
      status_seen[o.status]++;
      return o;
   endfunction

   // Driver: one command per transaction, with a random gap after each
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            due_results.insert(due_results.size(), command_result(req_payload));
            cmds_sent++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (cmd_backlog.size() != 0) begin
               req_valid   <= 1'b1;
               req_payload <= cmd_backlog.pop_front();
               req_gap     <= idle_draw();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Monitor: compare each result with the oldest prediction; ready drops at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_payload);
            mismatches++;
         end else begin
            check_field("status", 32'(due_results[0].status), 32'(rsp_payload.status));
            check_field("out_job_id", 32'(due_results[0].out_job_id),
                        32'(rsp_payload.out_job_id));
            check_field("out_priority", 32'(due_results[0].out_priority),
                        32'(rsp_payload.out_priority));
            check_field("out_attempt", 32'(due_results[0].out_attempt),
                        32'(rsp_payload.out_attempt));
            check_field("backoff_ms", 32'(due_results[0].backoff_ms),
                        32'(rsp_payload.backoff_ms));
            check_field("success_count", 32'(due_results[0].success_count),
                        32'(rsp_payload.success_count));
            check_field("failure_count", 32'(due_results[0].failure_count),
                        32'(rsp_payload.failure_count));
            check_field("occupancy", 32'(due_results[0].occupancy),
                        32'(rsp_payload.occupancy));
            void'(due_results.pop_front());
         end
         rsps_taken++;
         rsp_draw = (rsps_taken == HOLD_AT) ? HOLD_CYCLES : idle_draw();
         rsp_wait  <= rsp_draw;
         rsp_ready <= (rsp_draw == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void push_cmd(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                                    input logic [PRIO_W-1:0] p, input logic fl);
      req_type c;
      c.func         = f;
      c.job_id       = id;
      c.priority_req = p;
      c.failed       = fl;
      cmd_backlog.insert(cmd_backlog.size(), c);
   endfunction

   function automatic logic [PRIO_W-1:0] rand_prio();
      return ($urandom_range(0, 99) < 10) ? PRIO_W'($urandom_range(0, 15))
                                          : PRIO_W'($urandom_range(1, PRIO_TOP));
   endfunction

   function automatic void push_enqueue();
      push_cmd(FUNC_ENQUEUE, ID_W'($urandom_range(0, 65535)), rand_prio(),
               1'($urandom_range(0, 1)));
   endfunction

   // Mostly whole job lifecycles (enqueue bursts, dispatch then report, with
   // enqueues slipped in between to fill the store), plus some raw noise
   function automatic void add_random(input int n, input int enq_w, input int fail_pct);
      int made;
      int roll;
      int k;
      logic [FUNC_W-1:0] f;
      made = 0;
      while (made < n) begin
         roll = $urandom_range(0, 99);
         if (roll < enq_w) begin
            k = $urandom_range(1, 4);
            repeat (k) push_enqueue();
            made += k;
         end else if (roll < 90) begin
            push_cmd(FUNC_DISPATCH, ID_W'($urandom_range(0, 65535)), rand_prio(),
                     1'($urandom_range(0, 1)));
            k = ($urandom_range(0, 99) < 30) ? $urandom_range(1, 3) : 0;
            repeat (k) push_enqueue();
            push_cmd(FUNC_REPORT, ID_W'($urandom_range(0, 65535)), rand_prio(),
                     1'($urandom_range(0, 99) < fail_pct));
            made += k + 2;
         end else begin
            f = FUNC_W'($urandom_range(0, 3));
            push_cmd(f, ID_W'($urandom_range(0, 65535)), PRIO_W'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)));
            if (f != FUNC_SPARE) made++;
         end
      end
   endfunction

   // Sender pause: everything driven and every result back, then let the block settle
   task automatic drain();
      while (cmd_backlog.size() != 0 || req_valid || due_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_RETRY_LIMIT)
         retry_cap = LIMIT_W'(value);
      else
         base_ms = BASE_W'(value);
   endtask

   task automatic run_phase(input int lim, input int base, input int n, input int enq_w,
                            input int fail_pct, input bit fast);
      drain();
      csr_write(CSR_RETRY_LIMIT, lim);
      csr_write(CSR_BACKOFF_BASE, base);
      settings_used++;
      @(negedge clock);
      no_idle = fast;
      add_random(n, enq_w, fail_pct);
   endtask

   initial begin
      clear_model();
      for (int i = 0; i < 16; i++) status_seen[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset settings (retry limit 2, base 100)
      push_cmd(FUNC_DISPATCH, 16'h0000, 4'd1, 1'b0);   // empty store
      push_cmd(FUNC_REPORT, 16'h0000, 4'd1, 1'b1);     // nothing running
      push_cmd(FUNC_SPARE, 16'hFFFF, 4'hF, 1'b1);      // unused code
      push_cmd(FUNC_ENQUEUE, 16'hFFFF, 4'd0, 1'b0);    // priority raised to 1
      push_cmd(FUNC_ENQUEUE, 16'h0000, 4'hF, 1'b1);    // priority lowered to top
      push_cmd(FUNC_ENQUEUE, 16'h1234, 4'd10, 1'b0);   // tie, younger
      push_cmd(FUNC_DISPATCH, 16'h0000, 4'd0, 1'b0);
      push_cmd(FUNC_DISPATCH, 16'h0000, 4'd0, 1'b0);   // busy
      push_cmd(FUNC_REPORT, 16'h0000, 4'd0, 1'b1);     // requeue, priority stays at top
      push_cmd(FUNC_DISPATCH, 16'h0000, 4'd0, 1'b0);   // older tie wins
      push_cmd(FUNC_REPORT, 16'h0000, 4'd0, 1'b0);
      push_cmd(FUNC_DISPATCH, 16'h0000, 4'd0, 1'b0);   // first retry backoff
      push_cmd(FUNC_REPORT, 16'h0000, 4'd0, 1'b1);
      push_cmd(FUNC_DISPATCH, 16'h0000, 4'd0, 1'b0);   // doubled backoff
      push_cmd(FUNC_REPORT, 16'h0000, 4'd0, 1'b1);     // retries used up
      push_cmd(FUNC_ENQUEUE, 16'hAAAA, 4'd5, 1'b0);
      push_cmd(FUNC_DISPATCH, 16'h5555, 4'd0, 1'b0);
      push_cmd(FUNC_REPORT, 16'h0000, 4'd0, 1'b1);     // aging from the middle
      push_cmd(FUNC_DISPATCH, 16'h0000, 4'd0, 1'b0);
      push_cmd(FUNC_REPORT, 16'h0000, 4'd0, 1'b1);
      push_cmd(FUNC_DISPATCH, 16'h0000, 4'd0, 1'b0);
      push_cmd(FUNC_REPORT, 16'h0000, 4'd0, 1'b0);
      push_cmd(FUNC_DISPATCH, 16'h0000, 4'd0, 1'b0);
      push_cmd(FUNC_REPORT, 16'h0000, 4'd0, 1'b0);
      push_cmd(FUNC_REPORT, 16'h0000, 4'd0, 1'b1);

      // Random phases across register settings, extremes included
      run_phase(0, 0, 210, 30, 50, 1'b0);
      run_phase(15, 1023, 240, 45, 80, 1'b0);
      run_phase(1, 1, 200, 25, 40, 1'b1);
      run_phase($urandom_range(0, 15), $urandom_range(0, 1023), 200, 50, 60, 1'b0);
      run_phase(15, 0, 200, 35, 90, 1'b0);
      run_phase($urandom_range(0, 15), 512, 200, 40, 50, 1'b1);
      drain();

      $display("Run covered %0d commands over %0d register settings: enq %0d full %0d disp %0d",
               cmds_sent, settings_used, status_seen[RSP_ENQUEUED], status_seen[RSP_FULL],
               status_seen[RSP_DISPATCHED]);
      $display("  empty %0d busy %0d ok %0d requeue %0d final %0d dropped %0d none %0d",
               status_seen[RSP_EMPTY], status_seen[RSP_BUSY], status_seen[RSP_SUCCESS],
               status_seen[RSP_REQUEUED], status_seen[RSP_FINAL_FAIL],
               status_seen[RSP_DROPPED], status_seen[RSP_NONE]);
      if (mismatches == 0 && due_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[priority_retry_dispatcher.f]
hdl/prd_pkg.sv
hdl/prd_store.sv
hdl/prd_ctrl.sv
hdl/priority_retry_dispatcher.sv
tb/testbench.sv
